// ===== rtl/affa_pkg.sv =====
// Shared types and status codes of the aligned first-fit allocator.
`default_nettype none

package affa_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_ZERO_ALIGN = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_FULL       = 3'd4,
        ST_ORDER      = 3'd5,
        ST_ABORTED    = 3'd6
    } t_status;

    typedef struct packed {
        logic        starts_region;
        logic [15:0] buf_tag;
        logic [31:0] size_bytes;
        logic [31:0] align_bytes;
        logic [15:0] first_use;
        logic [15:0] last_use;
    } t_req;

    typedef struct packed {
        logic [15:0] result_id;
        logic [31:0] offset_bytes;
        t_status     status;
    } t_res;

    typedef struct packed {
        logic    load;
        logic    cmp_start;
        logic    cmp_step;
        logic    cmp_end;
        logic    walk_start;
        logic    place;
        logic    next_direct;
        logic    div_start;
        logic    div_step;
        logic    round_apply;
        logic    shift_rd;
        logic    shift_wr;
        logic    insert;
        logic    finish;
        t_status fin_code;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_status chk_code;
        logic    cmp_done;
        logic    full;
        logic    walk_end;
        logic    ovf_cand;
        logic    fits;
        logic    ovf_pend;
        logic    align_le1;
        logic    div_done;
        logic    ovf_round;
        logic    shift_done;
        logic    out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/aligned_first_fit_allocator.sv =====
// Top level of the aligned first-fit allocator.
`default_nettype none

// Takes one buffer request item at a time and answers each with one result item
// that holds the buffer id, the placed byte offset and a status code. Requests
// must arrive in ascending first-use order. For each request the block first
// checks the sticky error, the size, the alignment and the order; it then
// compacts the live table, dropping placements whose last use lies before this
// first use, and walks the survivors in offset order; when the alignment is
// above one, each row passed also needs a remainder, which is found one bit per
// cycle by a restoring unit. The new row is then inserted by shifting the rows
// above it up by one. The live table memory with its single read and single
// write port sets the pace of the compaction, walk and shift steps. A finished
// result item sits in an output register, so the block goes back to accept a
// new item while the result waits to be taken. After any error every later
// item is answered with aborted until an item marked as starting a region
// arrives, which clears the table and the sticky error first.
module aligned_first_fit_allocator #(
    parameter int LIVE_ENTRIES = 16,
    parameter int ADDR_BITS    = 32,
    parameter int INDEX_BITS   = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  affa_pkg::t_req    i_in_item,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output affa_pkg::t_res    o_out_item
);

    affa_pkg::t_cmd  cmd;
    affa_pkg::t_stat stat;

    affa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    affa_dp #(
        .LIVE_ENTRIES (LIVE_ENTRIES),
        .ADDR_BITS    (ADDR_BITS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/affa_ctrl.sv =====
// Sequencer of the allocator: checks, compaction, first-fit walk, insertion.
`default_nettype none

module affa_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  affa_pkg::t_stat   i_stat,
    output affa_pkg::t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_C_RD  = 13'b0000000000100,
        S_C_EV  = 13'b0000000001000,
        S_FULL  = 13'b0000000010000,
        S_W_RD  = 13'b0000000100000,
        S_W_EV  = 13'b0000001000000,
        S_DIV   = 13'b0000010000000,
        S_ROUND = 13'b0000100000000,
        S_S_RD  = 13'b0001000000000,
        S_S_WR  = 13'b0010000000000,
        S_INS   = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.fin_code  = affa_pkg::ST_OK;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.chk_code != affa_pkg::ST_OK) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.fin_code = i_stat.chk_code;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.cmp_start = 1'b1;
                    n_state         = S_C_RD;
                end
            end
            S_C_RD: begin
                if (i_stat.cmp_done) begin
                    o_cmd.cmp_end = 1'b1;
                    n_state       = S_FULL;
                end else begin
                    n_state = S_C_EV;
                end
            end
            S_C_EV: begin
                o_cmd.cmp_step = 1'b1;
                n_state        = S_C_RD;
            end
            S_FULL: begin
                if (i_stat.full) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.fin_code = affa_pkg::ST_FULL;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_W_RD;
                end
            end
            S_W_RD: begin
                if (i_stat.walk_end) begin
                    if (i_stat.ovf_cand) begin
                        o_cmd.finish   = 1'b1;
                        o_cmd.fin_code = affa_pkg::ST_OVERFLOW;
                        n_state        = S_RESP;
                    end else begin
                        o_cmd.place = 1'b1;
                        n_state     = S_S_RD;
                    end
                end else begin
                    n_state = S_W_EV;
                end
            end
            S_W_EV: begin
                if (i_stat.ovf_cand || (!i_stat.fits && i_stat.ovf_pend)) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.fin_code = affa_pkg::ST_OVERFLOW;
                    n_state        = S_RESP;
                end else if (i_stat.fits) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_S_RD;
                end else if (i_stat.align_le1) begin
                    o_cmd.next_direct = 1'b1;
                    n_state           = S_W_RD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_ROUND;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_ROUND: begin
                if (i_stat.ovf_round) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.fin_code = affa_pkg::ST_OVERFLOW;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.round_apply = 1'b1;
                    n_state           = S_W_RD;
                end
            end
            S_S_RD: begin
                if (i_stat.shift_done) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_S_WR;
                end
            end
            S_S_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_S_RD;
            end
            S_INS: begin
                o_cmd.insert   = 1'b1;
                o_cmd.finish   = 1'b1;
                o_cmd.fin_code = affa_pkg::ST_OK;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/affa_dp.sv =====
// Datapath of the allocator: live table memory, walk arithmetic, remainder unit, result register.
`default_nettype none

module affa_dp #(
    parameter int LIVE_ENTRIES = 16,
    parameter int ADDR_BITS    = 32,
    parameter int INDEX_BITS   = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  affa_pkg::t_req    i_in_item,
    input  affa_pkg::t_cmd    i_cmd,
    output affa_pkg::t_stat   o_stat,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output affa_pkg::t_res    o_out_item
);

    localparam int IW = $clog2(LIVE_ENTRIES);
    localparam int CW = IW + 1;
    localparam int MW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
    localparam int SW = MW + 1;
    localparam int EW = ADDR_BITS + 32 + INDEX_BITS;
    localparam int DW = $clog2(ADDR_BITS + 1);
    localparam logic [SW-1:0] LIM = {{(SW-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
    localparam logic [CW-1:0] FULL_COUNT = CW'(LIVE_ENTRIES);

    // Request and control registers.
    affa_pkg::t_req          r_req;
    logic                    r_sticky;
    logic [INDEX_BITS-1:0]   r_prev_fu;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_pos;
    logic [ADDR_BITS-1:0]    r_cand;
    logic [ADDR_BITS-1:0]    r_pend;
    logic [ADDR_BITS-1:0]    r_dsh;
    logic [32:0]             r_rem;
    logic [DW-1:0]           r_dcnt;
    affa_pkg::t_status       r_code;
    logic                    r_out_valid;
    affa_pkg::t_res          r_out;

    // Live table, one row per placement: offset, size, last use.
    logic [EW-1:0]           r_mem [LIVE_ENTRIES];
    logic [EW-1:0]           r_rd;
    logic [IW-1:0]           rd_addr;
    logic [IW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;
    logic                    wr_en;
    logic [CW-1:0]           idx_m1;

    logic [INDEX_BITS-1:0]   fu;
    logic [INDEX_BITS-1:0]   lu;
    logic [ADDR_BITS-1:0]    e_off;
    logic [31:0]             e_size;
    logic [INDEX_BITS-1:0]   e_lu;
    logic [SW-1:0]           sum_cs;
    logic [SW-1:0]           sum_pend;
    logic [31:0]             add_amt;
    logic [SW-1:0]           sum_round;
    logic [32:0]             div_tmp;
    logic [32:0]             align_ext;

    assign fu        = INDEX_BITS'(r_req.first_use);
    assign lu        = INDEX_BITS'(r_req.last_use);
    assign e_off     = r_rd[EW-1 -: ADDR_BITS];
    assign e_size    = r_rd[32+INDEX_BITS-1 -: 32];
    assign e_lu      = r_rd[INDEX_BITS-1:0];
    assign idx_m1    = r_idx - CW'(1);
    assign sum_cs    = SW'(r_cand) + SW'(r_req.size_bytes);
    assign sum_pend  = SW'(e_off) + SW'(e_size);
    assign align_ext = {1'b0, r_req.align_bytes};
    assign add_amt   = r_req.align_bytes - r_rem[31:0];
    assign sum_round = SW'(r_pend) + SW'(add_amt);
    assign div_tmp   = {r_rem[31:0], r_dsh[ADDR_BITS-1]};

    always_comb begin
        if (r_sticky) begin
            o_stat.chk_code = affa_pkg::ST_ABORTED;
        end else if (r_req.size_bytes == 32'd0) begin
            o_stat.chk_code = affa_pkg::ST_ZERO_SIZE;
        end else if (r_req.align_bytes == 32'd0) begin
            o_stat.chk_code = affa_pkg::ST_ZERO_ALIGN;
        end else if (fu < r_prev_fu) begin
            o_stat.chk_code = affa_pkg::ST_ORDER;
        end else begin
            o_stat.chk_code = affa_pkg::ST_OK;
        end
        o_stat.cmp_done   = (r_idx == r_count);
        o_stat.full       = (r_count == FULL_COUNT);
        o_stat.walk_end   = (r_idx == r_count);
        o_stat.ovf_cand   = (sum_cs > LIM);
        o_stat.fits       = (sum_cs <= SW'(e_off));
        o_stat.ovf_pend   = (sum_pend > LIM);
        o_stat.align_le1  = (r_req.align_bytes <= 32'd1);
        o_stat.div_done   = (r_dcnt == '0);
        o_stat.ovf_round  = (r_rem != 33'd0) && (sum_round > LIM);
        o_stat.shift_done = (r_idx == r_pos);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // Memory ports: compaction copies down, insertion shifts up, then writes the new row.
    always_comb begin
        rd_addr = i_cmd.shift_rd ? idx_m1[IW-1:0] : r_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_n[IW-1:0];
        wr_data = r_rd;
        if (i_cmd.cmp_step && !(e_lu < fu)) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[IW-1:0];
        end else if (i_cmd.insert) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[IW-1:0];
            wr_data = {r_cand, r_req.size_bytes, lu};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
        if (i_cmd.cmp_start) begin
            r_idx <= '0;
            r_n   <= '0;
        end
        if (i_cmd.cmp_step) begin
            r_idx <= r_idx + CW'(1);
            if (!(e_lu < fu)) begin
                r_n <= r_n + CW'(1);
            end
        end
        if (i_cmd.walk_start) begin
            r_idx  <= '0;
            r_cand <= '0;
        end
        if (i_cmd.place) begin
            r_pos <= r_idx;
            r_idx <= r_count;
        end
        if (i_cmd.next_direct) begin
            r_cand <= sum_pend[ADDR_BITS-1:0];
            r_idx  <= r_idx + CW'(1);
        end
        if (i_cmd.div_start) begin
            r_pend <= sum_pend[ADDR_BITS-1:0];
            r_dsh  <= sum_pend[ADDR_BITS-1:0];
            r_rem  <= '0;
            r_dcnt <= DW'(ADDR_BITS);
        end
        if (i_cmd.div_step) begin
            r_dsh  <= r_dsh << 1;
            r_dcnt <= r_dcnt - DW'(1);
            if (div_tmp >= align_ext) begin
                r_rem <= div_tmp - align_ext;
            end else begin
                r_rem <= div_tmp;
            end
        end
        if (i_cmd.round_apply) begin
            r_cand <= (r_rem == 33'd0) ? r_pend : sum_round[ADDR_BITS-1:0];
            r_idx  <= r_idx + CW'(1);
        end
        if (i_cmd.shift_wr) begin
            r_idx <= idx_m1;
        end
        if (i_cmd.finish) begin
            r_code <= i_cmd.fin_code;
        end
        if (i_cmd.emit) begin
            r_out.result_id    <= r_req.buf_tag;
            r_out.offset_bytes <= (r_code == affa_pkg::ST_OK) ? 32'(MW'(r_cand)) : 32'd0;
            r_out.status       <= r_code;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky    <= 1'b0;
            r_prev_fu   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_in_item.starts_region) begin
                r_sticky  <= 1'b0;
                r_prev_fu <= '0;
                r_count   <= '0;
            end
            if (i_cmd.cmp_end) begin
                r_count <= r_n;
            end
            if (i_cmd.insert) begin
                r_count   <= r_count + CW'(1);
                r_prev_fu <= fu;
            end
            if (i_cmd.finish && i_cmd.fin_code != affa_pkg::ST_OK
                    && i_cmd.fin_code != affa_pkg::ST_ABORTED) begin
                r_sticky <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
